>>> hw/rtl/cc20_pkg.sv
package cc20_pkg;

  // Cipher geometry
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned DR_W          = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam int unsigned STATE_WORDS   = 16;
  localparam int unsigned KEY_WORDS     = 8;
  localparam int unsigned NONCE_WORDS   = 3;
  localparam int unsigned BLOCK_BYTES   = 64;
  localparam int unsigned POS_W         = $clog2(BLOCK_BYTES);

  // Request queue in cc20_front, feeding cc20_back
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;

  typedef logic [31:0] word_t;
  typedef word_t [STATE_WORDS-1:0] block_t;

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_01    = 3'd0,
    CFG_KEY_23    = 3'd1,
    CFG_KEY_45    = 3'd2,
    CFG_KEY_67    = 3'd3,
    CFG_NONCE_01  = 3'd4,
    CFG_NONCE_2   = 3'd5,
    CFG_INIT_CTR  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINAL
  } core_state_e;

  typedef enum logic [1:0] {
    BK_NEED,
    BK_GEN,
    BK_READY
  } back_state_e;

  typedef struct packed {
    word_t [KEY_WORDS-1:0]   key;
    word_t [NONCE_WORDS-1:0] nonce;
  } cipher_cfg_t;

  typedef struct packed {
    logic  start;
    word_t counter;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_rsp_t;

endpackage

>>> hw/rtl/cc20_in_if.sv
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/cc20_out_if.sv
interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hw/rtl/chacha20_stream_cipher.sv
// Channel   Dir  Fields                  Handshake
// in_i      in   data_byte[8] last_byte  valid/ready, request taken when both high
// out_o     out  out_byte[8]  out_last   valid/ready, result taken when both high
// cfg       in   cfg_idx_i[3] cfg_wdata_i[64]  cfg_we_i, no back-pressure
//
// The first byte of each 64-byte block waits for block generation: one load,
// 8*DOUBLE_ROUNDS quarter-round steps on the shared four-lane round unit, one final add.
// The other bytes of a block (up to 63) pass at one per cycle while the output is not stalled.
// A four-entry request queue keeps taking bytes, while it has room, as a block is generated or the
// output stalls. Reset clears the queue, the position and sets the block counter to 1.
module chacha20_stream_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  cc20_in_if.sink                       in_i,
  cc20_out_if.source                    out_o
);
  import cc20_pkg::*;

  cipher_cfg_t cfg_q, cfg_d;
  word_t       init_ctr_q, init_ctr_d;
  logic        ctr_load;
  core_req_t   core_req;
  core_rsp_t   core_rsp;
  block_t      ks;

  cc20_in_if q_if ();

  // Write configuration registers
  always_comb begin
    cfg_d      = cfg_q;
    init_ctr_d = init_ctr_q;
    ctr_load   = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_KEY_01: begin
          cfg_d.key[0] = cfg_wdata_i[31:0];
          cfg_d.key[1] = cfg_wdata_i[63:32];
        end
        CFG_KEY_23: begin
          cfg_d.key[2] = cfg_wdata_i[31:0];
          cfg_d.key[3] = cfg_wdata_i[63:32];
        end
        CFG_KEY_45: begin
          cfg_d.key[4] = cfg_wdata_i[31:0];
          cfg_d.key[5] = cfg_wdata_i[63:32];
        end
        CFG_KEY_67: begin
          cfg_d.key[6] = cfg_wdata_i[31:0];
          cfg_d.key[7] = cfg_wdata_i[63:32];
        end
        CFG_NONCE_01: begin
          cfg_d.nonce[0] = cfg_wdata_i[31:0];
          cfg_d.nonce[1] = cfg_wdata_i[63:32];
        end
        CFG_NONCE_2: cfg_d.nonce[2] = cfg_wdata_i[31:0];
        CFG_INIT_CTR: begin
          init_ctr_d = cfg_wdata_i[31:0];
          ctr_load   = 1'b1;
        end
        default: ctr_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= '0;
      init_ctr_q <= 32'd1;
    end else begin
      cfg_q      <= cfg_d;
      init_ctr_q <= init_ctr_d;
    end
  end

  cc20_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_i),
    .req_o  (q_if)
  );

  cc20_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (core_req),
    .rsp_o  (core_rsp),
    .ks_o   (ks)
  );

  cc20_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctr_load_i (ctr_load),
    .init_ctr_i (init_ctr_d),
    .req_i      (q_if),
    .rsp_o      (out_o),
    .core_req_o (core_req),
    .core_rsp_i (core_rsp),
    .ks_i       (ks)
  );

endmodule

>>> hw/rtl/cc20_front.sv
module cc20_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  cc20_in_if.sink          req_i,
  cc20_in_if.source        req_o
);
  import cc20_pkg::*;

  logic [7:0]        data_q [QUEUE_DEPTH];
  logic              last_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  // Handshake on both sides of the queue
  assign req_i.ready     = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign req_o.valid     = (cnt_q != '0);
  assign req_o.data_byte = data_q[rd_ptr_q];
  assign req_o.last_byte = last_q[rd_ptr_q];

  assign push = req_i.valid && req_i.ready;
  assign pop  = req_o.valid && req_o.ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the request payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= req_i.data_byte;
      last_q[wr_ptr_q] <= req_i.last_byte;
    end
  end

endmodule

>>> hw/rtl/cc20_core.sv
module cc20_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cc20_pkg::cipher_cfg_t cfg_i,
  input  cc20_pkg::core_req_t   req_i,
  output cc20_pkg::core_rsp_t   rsp_o,
  output cc20_pkg::block_t      ks_o
);
  import cc20_pkg::*;

  core_state_e     state_q, state_d;
  block_t          w_q, w_d;
  block_t          ks_q, ks_d;
  block_t          init_start, init_final, w_round;
  word_t           ctr_q;
  logic [1:0]      step_q, step_d;
  logic            diag_q, diag_d;
  logic [DR_W-1:0] dr_q, dr_d;
  logic            last_step;

  function automatic word_t rotl(word_t x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic block_t build_init(cipher_cfg_t cfg, word_t ctr);
    block_t b;
    for (int i = 0; i < 4; i++) begin
      b[i] = SIGMA[i];
    end
    for (int i = 0; i < KEY_WORDS; i++) begin
      b[4 + i] = cfg.key[i];
    end
    b[12] = ctr;
    for (int i = 0; i < NONCE_WORDS; i++) begin
      b[13 + i] = cfg.nonce[i];
    end
    return b;
  endfunction

  assign init_start = build_init(cfg_i, req_i.counter);
  assign init_final = build_init(cfg_i, ctr_q);
  assign last_step  = (step_q == 2'd3) && diag_q && (dr_q == DR_W'(DOUBLE_ROUNDS - 1));

  // One quarter-round step on all four lanes of a column or diagonal round
  always_comb begin
    logic [1:0] lane;
    logic [3:0] ia, ib, ic, id;
    word_t      a, b, c, d;
    w_round = w_q;
    for (int l = 0; l < 4; l++) begin
      lane = 2'(l);
      ia   = {2'b00, lane};
      ib   = {2'b01, diag_q ? lane + 2'd1 : lane};
      ic   = {2'b10, diag_q ? lane + 2'd2 : lane};
      id   = {2'b11, diag_q ? lane + 2'd3 : lane};
      a    = w_q[ia];
      b    = w_q[ib];
      c    = w_q[ic];
      d    = w_q[id];
      case (step_q)
        2'd0: begin
          a = a + b;
          d = rotl(d ^ a, 16);
        end
        2'd1: begin
          c = c + d;
          b = rotl(b ^ c, 12);
        end
        2'd2: begin
          a = a + b;
          d = rotl(d ^ a, 8);
        end
        default: begin
          c = c + d;
          b = rotl(b ^ c, 7);
        end
      endcase
      w_round[ia] = a;
      w_round[ib] = b;
      w_round[ic] = c;
      w_round[id] = d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CORE_IDLE:  if (req_i.start) state_d = CORE_ROUND;
      CORE_ROUND: if (last_step) state_d = CORE_FINAL;
      CORE_FINAL: state_d = CORE_IDLE;
      default:    state_d = CORE_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.busy = (state_q != CORE_IDLE);
    rsp_o.done = (state_q == CORE_FINAL);
  end

  // Round counters
  always_comb begin
    step_d = step_q;
    diag_d = diag_q;
    dr_d   = dr_q;
    if (state_q == CORE_IDLE) begin
      step_d = '0;
      diag_d = 1'b0;
      dr_d   = '0;
    end else if (state_q == CORE_ROUND) begin
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        diag_d = !diag_q;
        if (diag_q) begin
          dr_d = last_step ? '0 : dr_q + DR_W'(1);
        end
      end
    end
  end

  // Working state and keystream
  always_comb begin
    w_d  = w_q;
    ks_d = ks_q;
    case (state_q)
      CORE_IDLE:  if (req_i.start) w_d = init_start;
      CORE_ROUND: w_d = w_round;
      CORE_FINAL: begin
        for (int i = 0; i < STATE_WORDS; i++) begin
          ks_d[i] = init_final[i] + w_q[i];
        end
      end
      default: w_d = w_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      step_q  <= '0;
      diag_q  <= 1'b0;
      dr_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      diag_q  <= diag_d;
      dr_q    <= dr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    ks_q <= ks_d;
    if ((state_q == CORE_IDLE) && req_i.start) begin
      ctr_q <= req_i.counter;
    end
  end

  assign ks_o = ks_q;

endmodule

>>> hw/rtl/cc20_back.sv
module cc20_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ctr_load_i,
  input  cc20_pkg::word_t     init_ctr_i,
  cc20_in_if.sink             req_i,
  cc20_out_if.source          rsp_o,
  output cc20_pkg::core_req_t core_req_o,
  input  cc20_pkg::core_rsp_t core_rsp_i,
  input  cc20_pkg::block_t    ks_i
);
  import cc20_pkg::*;

  back_state_e      state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  word_t            ctr_q, ctr_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_byte_q, ks_byte;
  logic             out_last_q;
  logic             out_free, pop, block_end;
  word_t            ks_word;

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign pop       = req_i.valid && req_i.ready;
  assign block_end = req_i.last_byte || (pos_q == POS_W'(BLOCK_BYTES - 1));

  // Pick the keystream byte for the current position
  assign ks_word = ks_i[pos_q[POS_W-1:2]];
  assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_NEED:  if (req_i.valid) state_d = BK_GEN;
      BK_GEN:   if (core_rsp_i.done) state_d = BK_READY;
      BK_READY: if (pop && block_end) state_d = BK_NEED;
      default:  state_d = BK_NEED;
    endcase
  end

  // Outputs
  always_comb begin
    core_req_o.start   = (state_q == BK_NEED) && req_i.valid && !core_rsp_i.busy;
    core_req_o.counter = ctr_q;
    req_i.ready        = (state_q == BK_READY) && out_free;
  end

  // Block position and counter
  always_comb begin
    pos_d = pos_q;
    ctr_d = ctr_q;
    if (pop) begin
      pos_d = req_i.last_byte ? '0 : pos_q + POS_W'(1);
    end
    if (ctr_load_i) begin
      ctr_d = init_ctr_i;
    end else if (core_rsp_i.done) begin
      ctr_d = ctr_q + 32'd1;
    end else if (pop && req_i.last_byte) begin
      ctr_d = init_ctr_i;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_NEED;
      pos_q     <= '0;
      ctr_q     <= 32'd1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      ctr_q     <= ctr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q <= req_i.data_byte ^ ks_byte;
      out_last_q <= req_i.last_byte;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.out_byte = out_byte_q;
  assign rsp_o.out_last = out_last_q;

endmodule
